/* design/psv_pkg.sv */
package psv_pkg;

    localparam int LINE_LENGTH = 4096;
    localparam int SAMPLE_BITS = 24;

    localparam int ADDR_W  = $clog2(LINE_LENGTH);
    localparam int DELAY_W = 20;
    localparam int COEF_W  = 17;
    localparam int EXT_W   = 24;
    localparam int OUT_W   = 24;
    localparam int SEED_W  = 32;

    localparam int SPAN     = LINE_LENGTH * 256;
    localparam int POS_W    = ADDR_W + 8;
    localparam int MW       = (((POS_W + 1) > DELAY_W) ? (POS_W + 1) : DELAY_W) + 1;
    localparam int DMAX_RAW = (LINE_LENGTH - 4) * 256;
    localparam int DMAX_INT = (DMAX_RAW > 1048575) ? 1048575 : DMAX_RAW;
    localparam int QMAX      = ((1 << DELAY_W) - 1) / SPAN;
    localparam int MOD_STEPS = (QMAX == 0) ? 1 : $clog2(QMAX + 1);
    localparam int MODK_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    localparam int MUL_W = 34;
    localparam int P_W   = 2 * MUL_W;
    localparam int EXC_W = 22;

    localparam logic [DELAY_W-1:0] DELAY_MIN   = DELAY_W'(512);
    localparam logic [DELAY_W-1:0] DELAY_MAX   = DELAY_W'(DMAX_INT);
    localparam logic [DELAY_W-1:0] RESET_DELAY = DELAY_W'(25600);
    localparam logic [COEF_W-1:0]  ONE_Q16     = COEF_W'(65536);
    localparam logic [COEF_W-1:0]  ENV_FLOOR   = COEF_W'(32);
    localparam logic [COEF_W-1:0]  RESET_STEP  = COEF_W'(262);
    localparam logic [SEED_W-1:0]  SEED_RESET  = 32'd100;
    localparam logic [SEED_W-1:0]  LCG_MUL     = 32'd1664525;
    localparam logic [SEED_W-1:0]  LCG_ADD     = 32'd1013904223;
    localparam logic [15:0]        GAIN_06     = 16'd39322;
    localparam int                 SILENT_BOUND = 10;

    typedef struct packed {
        logic                    pluck;
        logic [DELAY_W-1:0]      target_delay;
        logic [COEF_W-1:0]       damp_coef;
        logic [COEF_W-1:0]       loop_gain;
        logic                    invert_feedback;
        logic [COEF_W-1:0]       glide_coef;
        logic signed [EXT_W-1:0] ext_sample;
        logic [COEF_W-1:0]       exc_step;
    } psv_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample_out;
        logic                    voice_active;
    } psv_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GLIDE_MUL,
        ST_GLIDE_ADD,
        ST_MOD,
        ST_POS,
        ST_RD0,
        ST_RD1,
        ST_INTERP_MUL,
        ST_INTERP_ADD,
        ST_LP_MUL,
        ST_LP_ADD,
        ST_FB_MUL,
        ST_FB_ADD,
        ST_NZ_MUL,
        ST_NZ_ADD,
        ST_EG_MUL,
        ST_EXC_MUL,
        ST_DEC_MUL,
        ST_DEC_ADD,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

/* design/psv_ram.sv */
module psv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/plucked_string_voice_unit.sv */
// One request is taken in the idle state; a sounding voice then runs the glide, the
// delay reduction (one step per quotient bit, one at the default line length), the line
// reads, interpolation, loop filter and feedback, plus the exciter states while it runs.
// A silent voice goes straight to the result. The next request is taken in the cycle after
// the result is loaded; one shared 34x34 multiplier and one RAM read port set the pace.
// Reset is synchronous; unwritten delay-line entries read as zero through a fill mark.
module plucked_string_voice_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  psv_pkg::psv_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output psv_pkg::psv_out_t m_data
);
    import psv_pkg::*;

    localparam int SW    = SAMPLE_BITS;
    localparam int SUM_W = (((SW + 1) > EXT_W) ? (SW + 1) : EXT_W) + 2;
    localparam int OW    = ((SW > OUT_W) ? SW : OUT_W) + 1;

    localparam logic signed [SW+1:0]  LP_HI  = (SW + 2)'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [SW+1:0]  LP_LO  = -LP_HI - 1;
    localparam logic signed [SUM_W-1:0] SM_HI = SUM_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SM_LO = -SM_HI - 1;
    localparam logic signed [OW-1:0]  O_HI   = OW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [OW-1:0]  O_LO   = -O_HI - 1;
    localparam logic [MW-1:0]         SPAN_MW = MW'(SPAN);
    localparam logic signed [SW-1:0]  QUIET_HI = SW'(SILENT_BOUND);
    localparam logic signed [SW-1:0]  QUIET_LO = -QUIET_HI;

    function automatic logic [COEF_W-1:0] cap_one(input logic [COEF_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    state_t state_reg, state_next;

    logic [DELAY_W-1:0]       target_reg, target_next;
    logic [COEF_W-1:0]        damp_reg, damp_next;
    logic [COEF_W-1:0]        gain_reg, gain_next;
    logic [COEF_W-1:0]        glide_reg, glide_next;
    logic                     inv_reg, inv_next;
    logic signed [EXT_W-1:0]  ext_reg, ext_next;
    logic [DELAY_W-1:0]       cd_reg, cd_next;
    logic signed [SW-1:0]     lp_reg, lp_next;
    logic [COEF_W-1:0]        env_reg, env_next;
    logic [COEF_W-1:0]        step_reg, step_next;
    logic [SEED_W-1:0]        noise_reg, noise_next;
    logic                     active_reg, active_next;
    logic [ADDR_W-1:0]        wp_reg, wp_next;
    logic                     filled_reg, filled_next;
    logic                     neg_reg, neg_next;
    logic [MW-1:0]            rem_reg, rem_next;
    logic [MODK_W-1:0]        k_reg, k_next;
    logic [POS_W-1:0]         rp_reg, rp_next;
    logic signed [SW-1:0]     b0_reg, b0_next;
    logic signed [SW-1:0]     rd_reg, rd_next;
    logic signed [P_W-1:0]    prod_reg, prod_next;
    logic signed [SW:0]       fb_reg, fb_next;
    logic signed [EXC_W-1:0]  exc_reg, exc_next;
    logic                     zero_out_reg, zero_out_next;
    logic                     m_valid_reg, m_valid_next;
    psv_out_t                 m_data_reg, m_data_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [P_W-1:0]    mul_p;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [SW-1:0]            ram_rdata;
    logic [SW-1:0]            ram_wdata;

    logic [DELAY_W-1:0]       target_clamped;
    logic                     accept;
    logic [DELAY_W-1:0]       glide_mag;
    logic [DELAY_W-1:0]       glide_step;
    logic [DELAY_W-1:0]       cd_new;
    logic [MW-1:0]            span_k;
    logic [MW-1:0]            pos_sum;
    logic [MW-1:0]            pos_wrap;
    logic [ADDR_W-1:0]        idx0;
    logic [ADDR_W:0]          idx1_wide;
    logic [ADDR_W-1:0]        idx1;
    logic                     ok0, ok1;
    logic signed [SW-1:0]     b1_val;
    logic signed [SW:0]       diff_b;
    logic signed [SW:0]       diff_lp;
    logic signed [SW:0]       rd_wide;
    logic signed [SW+1:0]     lp_sum;
    logic signed [SW:0]       fb_raw;
    logic [34:0]              dec_sum;
    logic [COEF_W+1:0]        dec_val;
    logic signed [SUM_W-1:0]  sum_w;
    logic signed [SUM_W-1:0]  sum_sat;
    logic [ADDR_W:0]          wp_inc;
    logic signed [OW-1:0]     lp_o;
    logic signed [OW-1:0]     lp_o_sat;

    psv_ram #(
        .WIDTH (SW),
        .DEPTH (LINE_LENGTH)
    ) u_line (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign mul_p   = mul_a * mul_b;

    always_comb begin
        target_clamped = s_data.target_delay;
        if (target_clamped < DELAY_MIN) begin
            target_clamped = DELAY_MIN;
        end
        if (target_clamped > DELAY_MAX) begin
            target_clamped = DELAY_MAX;
        end
    end

    assign glide_mag  = (target_reg < cd_reg) ? (cd_reg - target_reg) : (target_reg - cd_reg);
    assign glide_step = prod_reg[DELAY_W+15:16];
    assign cd_new     = neg_reg ? (cd_reg - glide_step) : (cd_reg + glide_step);
    assign span_k     = SPAN_MW << k_reg;
    assign pos_sum    = MW'({wp_reg, 8'b0}) + SPAN_MW - rem_reg;
    assign pos_wrap   = (pos_sum >= SPAN_MW) ? (pos_sum - SPAN_MW) : pos_sum;
    assign idx0       = rp_reg[POS_W-1:8];
    assign idx1_wide  = {1'b0, idx0} + 1'b1;
    assign idx1       = (idx1_wide >= (ADDR_W + 1)'(LINE_LENGTH)) ? '0
                                                                 : idx1_wide[ADDR_W-1:0];
    assign ok0        = filled_reg || (idx0 < wp_reg);
    assign ok1        = filled_reg || (idx1 < wp_reg);
    assign b1_val     = ok1 ? $signed(ram_rdata) : '0;
    assign diff_b     = (SW + 1)'(b1_val) - (SW + 1)'(b0_reg);
    assign diff_lp    = (SW + 1)'(rd_reg) - (SW + 1)'(lp_reg);
    assign rd_wide    = (SW + 1)'(b0_reg) + (SW + 1)'(prod_reg >>> 8);
    assign lp_sum     = (SW + 2)'(lp_reg) + (SW + 2)'(prod_reg >>> 16);
    assign fb_raw     = (SW + 1)'(prod_reg >>> 16);
    assign dec_sum    = 35'(prod_reg[33:0]) + 35'd65535;
    assign dec_val    = dec_sum[34:16];
    assign sum_w      = SUM_W'(exc_reg) + SUM_W'(ext_reg) + SUM_W'(fb_reg);
    assign sum_sat    = (sum_w > SM_HI) ? SM_HI : ((sum_w < SM_LO) ? SM_LO : sum_w);
    assign ram_wdata  = sum_sat[SW-1:0];
    assign wp_inc     = {1'b0, wp_reg} + 1'b1;
    assign lp_o       = OW'(lp_reg);
    assign lp_o_sat   = (lp_o > O_HI) ? O_HI : ((lp_o < O_LO) ? O_LO : lp_o);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (active_reg || s_data.pluck) ? ST_GLIDE_MUL : ST_DONE;
                end
            end
            ST_GLIDE_MUL:  state_next = ST_GLIDE_ADD;
            ST_GLIDE_ADD:  state_next = ST_MOD;
            ST_MOD: begin
                if (k_reg == '0) begin
                    state_next = ST_POS;
                end
            end
            ST_POS:        state_next = ST_RD0;
            ST_RD0:        state_next = ST_RD1;
            ST_RD1:        state_next = ST_INTERP_MUL;
            ST_INTERP_MUL: state_next = ST_INTERP_ADD;
            ST_INTERP_ADD: state_next = ST_LP_MUL;
            ST_LP_MUL:     state_next = ST_LP_ADD;
            ST_LP_ADD:     state_next = ST_FB_MUL;
            ST_FB_MUL:     state_next = ST_FB_ADD;
            ST_FB_ADD:     state_next = (env_reg > ENV_FLOOR) ? ST_NZ_MUL : ST_SUM;
            ST_NZ_MUL:     state_next = ST_NZ_ADD;
            ST_NZ_ADD:     state_next = ST_EG_MUL;
            ST_EG_MUL:     state_next = ST_EXC_MUL;
            ST_EXC_MUL:    state_next = ST_DEC_MUL;
            ST_DEC_MUL:    state_next = ST_DEC_ADD;
            ST_DEC_ADD:    state_next = ST_SUM;
            ST_SUM:        state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        target_next   = target_reg;
        damp_next     = damp_reg;
        gain_next     = gain_reg;
        glide_next    = glide_reg;
        inv_next      = inv_reg;
        ext_next      = ext_reg;
        cd_next       = cd_reg;
        lp_next       = lp_reg;
        env_next      = env_reg;
        step_next     = step_reg;
        noise_next    = noise_reg;
        active_next   = active_reg;
        wp_next       = wp_reg;
        filled_next   = filled_reg;
        neg_next      = neg_reg;
        rem_next      = rem_reg;
        k_next        = k_reg;
        rp_next       = rp_reg;
        b0_next       = b0_reg;
        rd_next       = rd_reg;
        prod_next     = prod_reg;
        fb_next       = fb_reg;
        exc_next      = exc_reg;
        zero_out_next = zero_out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mul_a         = '0;
        mul_b         = '0;
        ram_we        = 1'b0;
        ram_raddr     = idx0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    target_next   = target_clamped;
                    damp_next     = cap_one(s_data.damp_coef);
                    gain_next     = cap_one(s_data.loop_gain);
                    glide_next    = cap_one(s_data.glide_coef);
                    inv_next      = s_data.invert_feedback;
                    ext_next      = s_data.ext_sample;
                    zero_out_next = !(active_reg || s_data.pluck);
                    if (s_data.pluck) begin
                        env_next    = ONE_Q16;
                        step_next   = s_data.exc_step;
                        active_next = 1'b1;
                    end
                end
            end
            ST_GLIDE_MUL: begin
                neg_next  = target_reg < cd_reg;
                mul_a     = MUL_W'($signed({1'b0, glide_mag}));
                mul_b     = MUL_W'($signed({1'b0, glide_reg}));
                prod_next = mul_p;
            end
            ST_GLIDE_ADD: begin
                cd_next  = cd_new;
                rem_next = MW'(cd_new);
                k_next   = MODK_W'(MOD_STEPS - 1);
            end
            ST_MOD: begin
                if (rem_reg >= span_k) begin
                    rem_next = rem_reg - span_k;
                end
                if (k_reg != '0) begin
                    k_next = k_reg - 1'b1;
                end
            end
            ST_POS: begin
                rp_next = pos_wrap[POS_W-1:0];
            end
            ST_RD0: begin
                ram_raddr = idx0;
            end
            ST_RD1: begin
                ram_raddr = idx1;
                b0_next   = ok0 ? $signed(ram_rdata) : '0;
            end
            ST_INTERP_MUL: begin
                mul_a     = MUL_W'(diff_b);
                mul_b     = MUL_W'($signed({1'b0, rp_reg[7:0]}));
                prod_next = mul_p;
            end
            ST_INTERP_ADD: begin
                rd_next = SW'(rd_wide);
            end
            ST_LP_MUL: begin
                mul_a     = MUL_W'($signed({1'b0, damp_reg}));
                mul_b     = MUL_W'(diff_lp);
                prod_next = mul_p;
            end
            ST_LP_ADD: begin
                if (lp_sum > LP_HI) begin
                    lp_next = SW'(LP_HI);
                end else if (lp_sum < LP_LO) begin
                    lp_next = SW'(LP_LO);
                end else begin
                    lp_next = SW'(lp_sum);
                end
            end
            ST_FB_MUL: begin
                mul_a     = MUL_W'(lp_reg);
                mul_b     = MUL_W'($signed({1'b0, gain_reg}));
                prod_next = mul_p;
            end
            ST_FB_ADD: begin
                fb_next  = inv_reg ? -fb_raw : fb_raw;
                exc_next = '0;
            end
            ST_NZ_MUL: begin
                mul_a     = MUL_W'($signed({1'b0, noise_reg}));
                mul_b     = MUL_W'($signed({1'b0, LCG_MUL}));
                prod_next = mul_p;
            end
            ST_NZ_ADD: begin
                noise_next = prod_reg[SEED_W-1:0] + LCG_ADD;
            end
            ST_EG_MUL: begin
                mul_a     = MUL_W'($signed({1'b0, env_reg}));
                mul_b     = MUL_W'($signed({1'b0, GAIN_06}));
                prod_next = mul_p;
            end
            ST_EXC_MUL: begin
                mul_a     = MUL_W'($signed(noise_reg));
                mul_b     = MUL_W'($signed({1'b0, prod_reg[31:0]}));
                prod_next = mul_p;
            end
            ST_DEC_MUL: begin
                exc_next  = EXC_W'(prod_reg >>> 43);
                mul_a     = MUL_W'($signed({1'b0, env_reg}));
                mul_b     = MUL_W'($signed({1'b0, step_reg}));
                prod_next = mul_p;
            end
            ST_DEC_ADD: begin
                if (dec_val >= {2'b0, env_reg}) begin
                    env_next = '0;
                end else begin
                    env_next = env_reg - dec_val[COEF_W-1:0];
                end
            end
            ST_SUM: begin
                ram_we = 1'b1;
                if (wp_inc >= (ADDR_W + 1)'(LINE_LENGTH)) begin
                    wp_next     = '0;
                    filled_next = 1'b1;
                end else begin
                    wp_next = wp_inc[ADDR_W-1:0];
                end
                if ((env_reg <= ENV_FLOOR) &&
                    (lp_reg <= QUIET_HI) && (lp_reg >= QUIET_LO) &&
                    (rd_reg <= QUIET_HI) && (rd_reg >= QUIET_LO)) begin
                    active_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.sample_out   = zero_out_reg ? '0 : OUT_W'(lp_o_sat);
                    m_data_next.voice_active = zero_out_reg ? 1'b0 : active_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase

        if (cfg_we) begin
            noise_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cd_reg      <= RESET_DELAY;
            lp_reg      <= '0;
            env_reg     <= '0;
            step_reg    <= RESET_STEP;
            noise_reg   <= SEED_RESET;
            active_reg  <= 1'b0;
            wp_reg      <= '0;
            filled_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cd_reg      <= cd_next;
            lp_reg      <= lp_next;
            env_reg     <= env_next;
            step_reg    <= step_next;
            noise_reg   <= noise_next;
            active_reg  <= active_next;
            wp_reg      <= wp_next;
            filled_reg  <= filled_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg   <= target_next;
        damp_reg     <= damp_next;
        gain_reg     <= gain_next;
        glide_reg    <= glide_next;
        inv_reg      <= inv_next;
        ext_reg      <= ext_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        k_reg        <= k_next;
        rp_reg       <= rp_next;
        b0_reg       <= b0_next;
        rd_reg       <= rd_next;
        prod_reg     <= prod_next;
        fb_reg       <= fb_next;
        exc_reg      <= exc_next;
        zero_out_reg <= zero_out_next;
        m_data_reg   <= m_data_next;
    end

endmodule

/* verif/voice_checker.sv */
`timescale 1ns / 1ps

module voice_checker
    import psv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_we,
    input  logic     [31:0] cfg_wdata,
    input  logic     s_valid,
    input  logic     s_ready,
    input  psv_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  psv_out_t m_data,
    output int       failures,
    output int       outstanding
);

    logic signed [SAMPLE_BITS-1:0] line_mem [LINE_LENGTH];
    int          wr_ptr;
    int          cur_delay;
    longint      lp_state;
    int          env;
    int          decay_step;
    logic [31:0] noise;
    logic        sounding;
    psv_out_t    expected_samples [$];
    int          requests_seen;
    int          results_seen;

    assign outstanding = requests_seen - results_seen;

    function automatic longint clip_sample(longint v);
        longint hi;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint unity_cap(logic [COEF_W-1:0] c);
        return (c > ONE_Q16) ? longint'(ONE_Q16) : longint'(c);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic step_string(input psv_in_t req, output psv_out_t res);
        longint tgt, damp, gain, glide, ext, delta, stepv;
        longint b0, b1, rd, fb, exc, nz, prod, dec;
        int     pos, i0, i1, frac;
        res = '0;
        if (req.pluck) begin
            env        = int'(ONE_Q16);
            decay_step = int'(req.exc_step);
            sounding   = 1'b1;
        end
        if (!sounding) begin
            return;
        end

        tgt = longint'(req.target_delay);
        if (tgt < DELAY_MIN) begin
            tgt = longint'(DELAY_MIN);
        end
        if (tgt > DELAY_MAX) begin
            tgt = longint'(DELAY_MAX);
        end
        damp  = unity_cap(req.damp_coef);
        gain  = unity_cap(req.loop_gain);
        glide = unity_cap(req.glide_coef);
        ext   = longint'(req.ext_sample);

        // The glide step is truncated toward zero, so it works on the magnitude.
        delta = tgt - cur_delay;
        stepv = (mag(delta) * glide) >>> 16;
        if (delta < 0) begin
            stepv = -stepv;
        end
        cur_delay = int'((cur_delay + stepv) & 64'hFFFFF);

        pos  = (wr_ptr * 256 + SPAN - (cur_delay % SPAN)) % SPAN;
        i0   = pos >> 8;
        frac = pos % 256;
        i1   = (i0 + 1 >= LINE_LENGTH) ? 0 : i0 + 1;
        b0   = longint'(line_mem[i0]);
        b1   = longint'(line_mem[i1]);
        rd   = b0 + (((b1 - b0) * frac) >>> 8);

        lp_state = clip_sample(lp_state + ((damp * (rd - lp_state)) >>> 16));
        fb = (lp_state * gain) >>> 16;
        if (req.invert_feedback) begin
            fb = -fb;
        end

        exc = 0;
        if (env > ENV_FLOOR) begin
            noise = noise * LCG_MUL + LCG_ADD;
            nz    = longint'($signed(noise));
            exc   = (nz * env * longint'(GAIN_06)) >>> 43;
            prod  = longint'(env) * decay_step;
            dec   = (prod + 65535) >>> 16;
            env   = (dec >= env) ? 0 : env - int'(dec);
        end

        line_mem[wr_ptr] = SAMPLE_BITS'(clip_sample(exc + ext + fb));
        wr_ptr = (wr_ptr + 1) % LINE_LENGTH;

        if (env <= ENV_FLOOR && mag(lp_state) <= SILENT_BOUND && mag(rd) <= SILENT_BOUND) begin
            sounding = 1'b0;
        end
        res.sample_out   = OUT_W'(lp_state);
        res.voice_active = sounding;
    endtask

    always @(posedge aclk) begin
        psv_out_t want;
        if (!aresetn) begin
            for (int k = 0; k < LINE_LENGTH; k++) begin
                line_mem[k] = '0;
            end
            wr_ptr     = 0;
            cur_delay  = int'(RESET_DELAY);
            lp_state   = 0;
            env        = 0;
            decay_step = int'(RESET_STEP);
            noise      = SEED_RESET;
            sounding   = 1'b0;
            failures   = 0;
            expected_samples.delete();
            requests_seen <= 0;
            results_seen  <= 0;
        end else begin
            if (cfg_we) begin
                noise = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_samples.size() == 0) begin
                    $display("%0t: result with no request pending: got %0d/%0b", $time,
                             m_data.sample_out, m_data.voice_active);
                    failures++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_data.sample_out !== want.sample_out) begin
                        $display("%0t: sample_out expected %0d, got %0d", $time,
                                 want.sample_out, m_data.sample_out);
                        failures++;
                    end
                    if (m_data.voice_active !== want.voice_active) begin
                        $display("%0t: voice_active expected %0b, got %0b", $time,
                                 want.voice_active, m_data.voice_active);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                step_string(s_data, want);
                expected_samples.push_back(want);
                requests_seen <= requests_seen + 1;
            end
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import psv_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    psv_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    psv_out_t    m_data;
    int          failures;
    int          outstanding;
    int          idle_pct  = 0;
    int          stall_pct = 0;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    plucked_string_voice_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    voice_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    function automatic psv_in_t voice_req(input logic pluck, input logic [DELAY_W-1:0] tgt,
                                          input logic [COEF_W-1:0] damp,
                                          input logic [COEF_W-1:0] gain, input logic inv,
                                          input logic [COEF_W-1:0] glide,
                                          input logic [EXT_W-1:0] ext,
                                          input logic [COEF_W-1:0] step);
        psv_in_t r;
        r.pluck           = pluck;
        r.target_delay    = tgt;
        r.damp_coef       = damp;
        r.loop_gain       = gain;
        r.invert_feedback = inv;
        r.glide_coef      = glide;
        r.ext_sample      = ext;
        r.exc_step        = step;
        return r;
    endfunction

    task automatic send_request(input psv_in_t req);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Each note mostly opens with a pluck and runs on for a run of samples with mostly steady
    // settings, so the delay line holds past samples and the feedback loop gets exercised.
    task automatic play_notes(input int count);
        psv_in_t voice;
        psv_in_t req;
        int      note_len;
        int      sent;
        int      pick;
        sent = 0;
        while (sent < count) begin
            voice = '0;
            voice.target_delay = ($urandom_range(0, 9) < 7) ?
                                 DELAY_W'($urandom_range(512, 8192)) : DELAY_W'($urandom);
            voice.damp_coef = ($urandom_range(0, 3) != 0) ?
                              COEF_W'($urandom_range(16384, 65536)) : COEF_W'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                voice.loop_gain = COEF_W'($urandom_range(50000, 65536));
            end else if (pick < 8) begin
                voice.loop_gain = COEF_W'($urandom_range(0, 50000));
            end else begin
                voice.loop_gain = COEF_W'($urandom);
            end
            voice.invert_feedback = 1'($urandom_range(0, 1));
            voice.glide_coef = ($urandom_range(0, 3) != 0) ?
                               COEF_W'($urandom_range(0, 65536)) : COEF_W'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                voice.exc_step = COEF_W'($urandom_range(300, 4000));
            end else if (pick < 8) begin
                voice.exc_step = COEF_W'($urandom_range(4000, 65536));
            end else begin
                voice.exc_step = COEF_W'($urandom);
            end
            note_len = $urandom_range(4, 48);
            for (int j = 0; j < note_len && sent < count; j++) begin
                req = voice;
                req.pluck = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 63) == 0);
                case ($urandom_range(0, 15))
                    0: req.ext_sample = EXT_W'($urandom);
                    1, 2: req.ext_sample = EXT_W'(int'($urandom_range(0, 4095)) - 2048);
                    3: req.target_delay = DELAY_W'($urandom);
                    4: req.damp_coef = COEF_W'($urandom);
                    5: req.loop_gain = COEF_W'($urandom);
                    6: req.glide_coef = COEF_W'($urandom);
                    7: req.exc_step = COEF_W'($urandom);
                    8: req.invert_feedback = ~req.invert_feedback;
                    default: ;
                endcase
                send_request(req);
                sent++;
            end
        end
    endtask

    initial begin
        logic [31:0] seed;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(voice_req(1'b0, 20'hFFFFF, 17'h1FFFF, 17'h1FFFF, 1'b1, 17'h1FFFF,
                               24'h7FFFFF, 17'h1FFFF));
        send_request(voice_req(1'b1, 20'd0, 17'h1FFFF, 17'h1FFFF, 1'b1, 17'h1FFFF,
                               24'h7FFFFF, 17'd0));
        send_request(voice_req(1'b0, 20'd0, 17'd65536, 17'd65536, 1'b0, 17'd65536,
                               24'h800000, 17'd1));
        send_request(voice_req(1'b0, 20'd1, 17'd0, 17'd0, 1'b0, 17'd0, 24'h000000, 17'd0));
        send_request(voice_req(1'b0, 20'hFFFFF, 17'd32768, 17'd65535, 1'b1, 17'd1,
                               24'hFFFFFF, 17'd0));
        send_request(voice_req(1'b0, 20'hFFFFF, 17'd65536, 17'd65536, 1'b0, 17'd65536,
                               24'h000000, 17'd0));
        send_request(voice_req(1'b1, 20'd600, 17'd65536, 17'd65536, 1'b1, 17'd65536,
                               24'h7FFFFF, 17'd1));
        for (int k = 0; k < 5; k++) begin
            send_request(voice_req(1'b0, 20'd600, 17'd40000, 17'd65536, 1'b1, 17'd65536,
                                   24'h800000, 17'd0));
        end
        // An exciter step above one empties the envelope at once; reading unwritten
        // line entries then lets the voice retire on the same sample.
        send_request(voice_req(1'b1, 20'hFFFFF, 17'h1FFFF, 17'd0, 1'b0, 17'h1FFFF,
                               24'h000000, 17'h1FFFF));
        send_request(voice_req(1'b0, 20'd700, 17'd65536, 17'd65536, 1'b0, 17'd65536,
                               24'h7FFFFF, 17'd0));
        send_request(voice_req(1'b1, 20'd512, 17'd1000, 17'd65536, 1'b0, 17'd30000,
                               24'h000000, 17'd65536));
        for (int k = 0; k < 4; k++) begin
            send_request(voice_req(1'b0, 20'd512, 17'd1000, 17'd65536, 1'b0, 17'd30000,
                                   24'h000400, 17'd0));
        end

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    seed      = '0;
                end
                1: begin
                    idle_pct  = 85;
                    stall_pct = 0;
                    seed      = 32'h0000_0000;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 85;
                    seed      = 32'hFFFF_FFFF;
                end
                3: begin
                    idle_pct  = 28;
                    stall_pct = 28;
                    seed      = $urandom;
                end
                default: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    seed      = $urandom;
                end
            endcase
            if (phase != 0) begin
                cfg_we    <= 1'b1;
                cfg_wdata <= seed;
                @(posedge aclk);
                cfg_we    <= 1'b0;
            end
            play_notes(160);
            s_valid <= 1'b0;
            do @(posedge aclk); while (outstanding != 0);
        end

        repeat (30) @(posedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
